### rtl/mxs_pkg.sv
// mxs_pkg: shared types, opcodes and status codes for the max_stack block.
// No dependencies; imported by mxs_ctrl, mxs_dp and max_stack.
package mxs_pkg;

  localparam int VAL_W  = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int IN_W   = 40;  // op + value, padded to whole bytes
  localparam int OUT_W  = 40;  // result_value + status, padded to whole bytes

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [OP_W-1:0]         op_t;
  typedef logic [STAT_W-1:0]       status_t;

  localparam op_t OP_PUSH  = 3'd0;
  localparam op_t OP_POP   = 3'd1;
  localparam op_t OP_TOP   = 3'd2;
  localparam op_t OP_MAX   = 3'd3;
  localparam op_t OP_RMMAX = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch incoming item
    logic exec;        // single-step ops, write result
    logic scan_start;  // begin maximum scan
    logic scan_step;   // compare one cell
    logic finish;      // write maximum result, remove if asked
  } mxs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic scan_done;
  } mxs_sts_t;

endpackage

### rtl/mxs_ctrl.sv
// mxs_ctrl: command sequencer for max_stack, owns the stream handshakes.
// Depends on mxs_pkg; drives mxs_dp through mxs_cmd_t.
module mxs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mxs_pkg::mxs_sts_t sts,
  output mxs_pkg::mxs_cmd_t cmd
);
  import mxs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       is_max;

  assign out_free   = !out_valid_r || out_tready;
  assign is_max     = (sts.op == OP_MAX) || (sts.op == OP_RMMAX);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_max && !sts.empty) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !sts.empty)
    else $error("maximum scan started on an empty stack");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.finish) |-> (!out_valid_r || out_tready))
    else $error("result written over an untaken item");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC) && !in_tready)
    else $error("accepted item not taken into execution");

endmodule

### rtl/mxs_dp.sv
// mxs_dp: stack cell row, maximum scan unit and result register for max_stack.
// Depends on mxs_pkg; sequenced by mxs_ctrl.
module mxs_dp #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mxs_pkg::op_t      in_op,
  input  mxs_pkg::val_t     in_value,
  input  mxs_pkg::mxs_cmd_t cmd,
  output mxs_pkg::mxs_sts_t sts,
  output mxs_pkg::val_t     out_value,
  output mxs_pkg::status_t  out_status
);
  import mxs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // cell 0 is the top of the stack
  val_t          cell_r [DEPTH];
  val_t          dn_in  [DEPTH];
  val_t          up_in  [DEPTH];
  logic [DEPTH-1:0] up_mask;

  op_t           cmd_op_r;
  val_t          cmd_val_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r;
  logic [IW-1:0] best_idx_r;
  val_t          best_val_r;
  val_t          scan_rd;
  val_t          out_value_r;
  status_t       out_status_r;

  logic empty, full;
  logic push_en, pop_en, rm_en;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign push_en = cmd.exec && (cmd_op_r == OP_PUSH) && !full;
  assign pop_en  = cmd.exec && (cmd_op_r == OP_POP) && !empty;
  assign rm_en   = cmd.finish && (cmd_op_r == OP_RMMAX);
  assign scan_rd = cell_r[scan_idx_r[IW-1:0]];

  assign sts.op        = cmd_op_r;
  assign sts.empty     = empty;
  assign sts.scan_done = (scan_idx_r == count_r);

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    for (int t = 0; t < DEPTH; t++) begin
      up_mask[t] = pop_en || (rm_en && (IW'(t) >= best_idx_r));
    end
  end

  for (genvar t = 0; t < DEPTH; t++) begin : g_cell
    if (t == 0) begin : g_top
      assign dn_in[t] = cmd_val_r;
    end else begin : g_below
      assign dn_in[t] = cell_r[t-1];
    end
    if (t == DEPTH - 1) begin : g_bottom
      assign up_in[t] = cell_r[t];
    end else begin : g_above
      assign up_in[t] = cell_r[t+1];
    end

    always_ff @(posedge clk) begin
      if (push_en) begin
        cell_r[t] <= dn_in[t];
      end else if (up_mask[t]) begin
        cell_r[t] <= up_in[t];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_en || rm_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_op_r  <= in_op;
      cmd_val_r <= in_value;
    end
  end

  // strict greater keeps the topmost of equal maxima
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_val_r <= cell_r[0];
      best_idx_r <= '0;
      scan_idx_r <= CW'(1);
    end else if (cmd.scan_step) begin
      if (scan_rd > best_val_r) begin
        best_val_r <= scan_rd;
        best_idx_r <= scan_idx_r[IW-1:0];
      end
      scan_idx_r <= scan_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r  <= best_val_r;
      out_status_r <= ST_OK;
    end else if (cmd.exec) begin
      case (cmd_op_r)
        OP_PUSH: begin
          out_value_r  <= '0;
          out_status_r <= full ? ST_FULL : ST_OK;
        end
        OP_POP, OP_TOP: begin
          out_value_r  <= empty ? val_t'(0) : cell_r[0];
          out_status_r <= empty ? ST_EMPTY : ST_OK;
        end
        OP_MAX, OP_RMMAX: begin
          out_value_r  <= '0;
          out_status_r <= empty ? ST_EMPTY : ST_OK;
        end
        default: begin
          out_value_r  <= '0;
          out_status_r <= ST_OK;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (scan_idx_r < count_r))
    else $error("scan read beyond the filled cells");

  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |=> (cell_r[0] == $past(cmd_val_r)))
    else $error("pushed value not on top");

endmodule

### rtl/max_stack.sv
// Bounded stack of signed 32-bit values that can also return and remove its
// maximum. Each command item gives exactly one result item. Push, pop, read top,
// unknown ops and any read or removal on an empty stack go through a latch step
// and an execute step that writes the result register. Read maximum and remove
// maximum on a stack of n >= 1 entries run a compare scan that visits one stack
// cell per cycle from the top down, leave the scan and then write the result
// register in a finish step; ties go to the entry nearest the top. A result still
// waiting in the output register holds the execute or finish step until it is
// taken. One item is in work at a time; the next one is accepted as soon as the
// previous result is in the output register, even if that result has not yet been
// taken.
// Depends on mxs_pkg, mxs_ctrl and mxs_dp.
module max_stack #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [mxs_pkg::IN_W-1:0] in_tdata,   // [2:0] op, [34:3] value, rest zero
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [mxs_pkg::OUT_W-1:0] out_tdata  // [31:0] result_value, [33:32] status
);
  import mxs_pkg::*;

  mxs_cmd_t cmd;
  mxs_sts_t sts;
  op_t      in_op;
  val_t     in_value;
  val_t     res_value;
  status_t  res_status;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_value  = in_tdata[OP_W+VAL_W-1:OP_W];
  assign out_tdata = {(OUT_W - VAL_W - STAT_W)'(0), res_status, res_value};

  mxs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mxs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_op),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_value  (res_value),
    .out_status (res_status)
  );

endmodule
